// ===== hw/rtl/fmd_pkg.sv =====
// ----------------------------------------------------------------------------
// fmd_pkg
// Shared types and constants for the framed message deframer.
// ----------------------------------------------------------------------------
package fmd_pkg;

  localparam logic [7:0] SyncByte = 8'hAA;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_DATA    = 3'd1,
    EV_ACCEPT  = 3'd2,
    EV_REJECT  = 3'd3,
    EV_ZEROLEN = 3'd4
  } event_kind_e;

  typedef struct packed {
    event_kind_e event_kind;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic [7:0]  command_id;
    logic [7:0]  payload_count;
  } fmd_result_t;

endpackage

// ===== hw/rtl/framed_message_deframer.sv =====
// ----------------------------------------------------------------------------
// framed_message_deframer
// Length-prefixed frame parser with XOR checksum, one event per input byte.
// ----------------------------------------------------------------------------
// Each byte passes the input register, then the result register, on its way to an event.
// Throughput: one byte per cycle while the event side takes events; the frame state updates in a single pass.
// Stalls on the event side back up through the input register.
// Reset clears frame state and both stage valids; the parser starts hunting.
module framed_message_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [7:0] data_byte, [15:8] byte_index,
                                        // [23:16] command_id, [31:24] payload_count
  output logic [2:0]  m_axis_tuser_o    // [2:0] event_kind
);
  import fmd_pkg::*;

  logic        in_valid;
  logic [7:0]  rx_byte;
  logic        advance;
  fmd_result_t result;

  assign advance = in_valid && (!m_axis_tvalid_o || m_axis_tready_i);

  fmd_in_stage u_in (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .advance_i       (advance),
    .valid_o         (in_valid),
    .rx_byte_o       (rx_byte)
  );

  fmd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .rx_byte_i (rx_byte),
    .result_o  (result)
  );

  fmd_out_stage u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (advance),
    .result_i        (result),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

// ===== hw/rtl/fmd_in_stage.sv =====
// ----------------------------------------------------------------------------
// fmd_in_stage
// Input register holding one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module fmd_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] rx_byte
  input  logic       advance_i,
  output logic       valid_o,
  output logic [7:0] rx_byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;
  logic       take;

  assign s_axis_tready_o = !valid_q || advance_i;
  assign take            = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    if (take) begin
      valid_d = 1'b1;
      byte_d  = s_axis_tdata_i;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign valid_o   = valid_q;
  assign rx_byte_o = byte_q;

endmodule

// ===== hw/rtl/fmd_parser.sv =====
// ----------------------------------------------------------------------------
// fmd_parser
// Frame state, running XOR checksum and event decode for one byte a cycle while advance_i is high.
// ----------------------------------------------------------------------------
module fmd_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               advance_i,
  input  logic [7:0]         rx_byte_i,
  output fmd_pkg::fmd_result_t result_o
);
  import fmd_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_LEN  = 3'd1,
    PH_CMD  = 3'd2,
    PH_PAY  = 3'd3,
    PH_CHK  = 3'd4
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [7:0]  xor_q, xor_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [7:0]  cnt_inc;
  fmd_result_t res;

  assign cnt_inc = cnt_q + 8'd1;

  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    cmd_d   = cmd_q;
    xor_d   = xor_q;
    cnt_d   = cnt_q;
    res     = '0;
    res.event_kind = EV_NONE;
    unique case (phase_q)
      PH_LEN: begin
        if (rx_byte_i == 8'd0) begin
          res.event_kind = EV_ZEROLEN;
        end else begin
          xor_d   = xor_q ^ rx_byte_i;
          len_d   = rx_byte_i;
          phase_d = PH_CMD;
        end
      end
      PH_CMD: begin
        xor_d   = xor_q ^ rx_byte_i;
        cmd_d   = rx_byte_i;
        cnt_d   = 8'd0;
        phase_d = (len_q == 8'd1) ? PH_CHK : PH_PAY;
      end
      PH_PAY: begin
        xor_d          = xor_q ^ rx_byte_i;
        res.event_kind = EV_DATA;
        res.data_byte  = rx_byte_i;
        res.byte_index = cnt_q;
        cnt_d          = cnt_inc;
        // payload is len - 1 bytes
        if (cnt_inc + 8'd1 == len_q) begin
          phase_d = PH_CHK;
        end
      end
      PH_CHK: begin
        res.event_kind    = (rx_byte_i == xor_q) ? EV_ACCEPT : EV_REJECT;
        res.command_id    = cmd_q;
        res.payload_count = len_q - 8'd1;
        phase_d = PH_HUNT;
        len_d   = 8'd0;
        cmd_d   = 8'd0;
        xor_d   = 8'd0;
        cnt_d   = 8'd0;
      end
      default: begin
        if (rx_byte_i == SyncByte) begin
          phase_d = PH_LEN;
          cnt_d   = 8'd0;
          xor_d   = 8'd0;
        end else begin
          phase_d = PH_HUNT;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      len_q   <= 8'd0;
      cmd_q   <= 8'd0;
      xor_q   <= 8'd0;
      cnt_q   <= 8'd0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      cmd_q   <= cmd_d;
      xor_q   <= xor_d;
      cnt_q   <= cnt_d;
    end
  end

  assign result_o = res;

  // checks
  a_hunt_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HUNT |-> (xor_q == 8'd0 && cnt_q == 8'd0))
    else $error("fmd_parser: stale checksum or count while hunting");

  a_pay_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAY |-> cnt_q < len_q)
    else $error("fmd_parser: payload index past frame length");

  a_verdict_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && phase_q == PH_CHK) |=> phase_q == PH_HUNT)
    else $error("fmd_parser: frame not closed after verdict");

  a_data_only_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.event_kind != EV_DATA |-> (res.data_byte == 8'd0 && res.byte_index == 8'd0))
    else $error("fmd_parser: data fields set outside payload");

endmodule

// ===== hw/rtl/fmd_out_stage.sv =====
// ----------------------------------------------------------------------------
// fmd_out_stage
// Result register driving the outgoing event stream.
// ----------------------------------------------------------------------------
module fmd_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  fmd_pkg::fmd_result_t result_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [31:0]          m_axis_tdata_o,
  output logic [2:0]           m_axis_tuser_o
);
  import fmd_pkg::*;

  logic        valid_q, valid_d;
  fmd_result_t res_q, res_d;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (load_i) begin
      valid_d = 1'b1;
      res_d   = result_i;
    end else if (m_axis_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tuser_o  = res_q.event_kind;
  assign m_axis_tdata_o  = {res_q.payload_count, res_q.command_id,
                            res_q.byte_index, res_q.data_byte};

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives byte streams into the framed message deframer: idle noise, shortest
// and longest frames, zero length bytes, the start byte inside a frame, then
// mostly well-formed random frames mixed with noise and cut-off frames. Each
// accepted byte is run through a local frame parser and the event it should
// raise is queued; every event leaving the block is checked against the
// oldest queued one. Sender and receiver both throttle at random.
// ----------------------------------------------------------------------------
module testbench;
  import fmd_pkg::*;

  localparam int unsigned IdleLimit = 1000;
  localparam int unsigned RandomBytes = 520;
  localparam int unsigned DrainCycles = 8;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LENGTH,
    PH_COMMAND,
    PH_PAYLOAD,
    PH_CHECK
  } parse_phase_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 8'd0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;

  framed_message_deframer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Local frame parser state
  parse_phase_e parse_phase = PH_HUNT;
  logic [7:0]   frame_len = 8'd0;
  logic [7:0]   cmd_byte = 8'd0;
  logic [7:0]   xor_sum = 8'd0;
  logic [7:0]   pay_idx = 8'd0;

  fmd_result_t  pending_events[$];
  int unsigned  mismatches = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  burst_left = 0;

  function automatic fmd_result_t parse_rx_byte(input logic [7:0] b);
    fmd_result_t ev;
    ev = '0;
    case (parse_phase)
      PH_LENGTH: begin
        if (b == 8'd0) begin
          ev.event_kind = EV_ZEROLEN;
        end else begin
          xor_sum = xor_sum ^ b;
          frame_len = b;
          parse_phase = PH_COMMAND;
        end
      end
      PH_COMMAND: begin
        xor_sum = xor_sum ^ b;
        cmd_byte = b;
        pay_idx = 8'd0;
        parse_phase = (frame_len == 8'd1) ? PH_CHECK : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        xor_sum = xor_sum ^ b;
        ev.event_kind = EV_DATA;
        ev.data_byte = b;
        ev.byte_index = pay_idx;
        pay_idx = pay_idx + 8'd1;
        if (pay_idx + 8'd1 == frame_len) parse_phase = PH_CHECK;
      end
      PH_CHECK: begin
        ev.event_kind = (b == xor_sum) ? EV_ACCEPT : EV_REJECT;
        ev.command_id = cmd_byte;
        ev.payload_count = frame_len - 8'd1;
        parse_phase = PH_HUNT;
        frame_len = 8'd0;
        cmd_byte = 8'd0;
        xor_sum = 8'd0;
        pay_idx = 8'd0;
      end
      default: begin
        if (b == SyncByte) begin
          parse_phase = PH_LENGTH;
          pay_idx = 8'd0;
          xor_sum = 8'd0;
        end
      end
    endcase
    return ev;
  endfunction

  // Check events leaving the block, then queue the event for a new request
  always @(posedge clk_i) begin
    fmd_result_t got;
    fmd_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.event_kind    = event_kind_e'(m_axis_tuser_o);
        got.data_byte     = m_axis_tdata_o[7:0];
        got.byte_index    = m_axis_tdata_o[15:8];
        got.command_id    = m_axis_tdata_o[23:16];
        got.payload_count = m_axis_tdata_o[31:24];
        if (pending_events.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected event: kind=%0d data=%h idx=%0d cmd=%h cnt=%0d",
                     got.event_kind, got.data_byte, got.byte_index,
                     got.command_id, got.payload_count);
          end
          mismatches++;
        end else begin
          want = pending_events.pop_front();
          if (got.event_kind !== want.event_kind || got.data_byte !== want.data_byte ||
              got.byte_index !== want.byte_index || got.command_id !== want.command_id ||
              got.payload_count !== want.payload_count) begin
            if (mismatches < 10) begin
              $display("mismatch: want kind=%0d data=%h idx=%0d cmd=%h cnt=%0d",
                       want.event_kind, want.data_byte, want.byte_index,
                       want.command_id, want.payload_count);
              $display("          got  kind=%0d data=%h idx=%0d cmd=%h cnt=%0d",
                       got.event_kind, got.data_byte, got.byte_index,
                       got.command_id, got.payload_count);
            end
            mismatches++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        pending_events.push_back(parse_rx_byte(s_axis_tdata_i));
      end
    end
  end

  // Receiver stall pattern: changes character after each run of random length
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;
  int unsigned stall_tick = 0;

  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 1;
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(32, 256);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: m_axis_tready_i <= 1'b1;
      1: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
      2: m_axis_tready_i <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready_i <= (stall_tick % 7 == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One request on the byte side; bursts of random length, random gaps between
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
      if (gap != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 32);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    burst_left--;
  endtask

  // fill < 0 gives random payload
  task automatic send_frame(input logic [7:0] len, input logic [7:0] cmd, input bit good,
                            input int zeros, input int fill);
    logic [7:0] sum;
    logic [7:0] p;
    send_byte(SyncByte);
    repeat (zeros) send_byte(8'd0);
    send_byte(len);
    sum = len;
    send_byte(cmd);
    sum = sum ^ cmd;
    for (int i = 1; i < len; i++) begin
      p = (fill < 0) ? 8'($urandom) : 8'(fill);
      sum = sum ^ p;
      send_byte(p);
    end
    send_byte(good ? sum : sum ^ 8'($urandom_range(1, 255)));
  endtask

  task automatic test_hunt_noise();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_byte(8'hA9);
    send_byte(8'hAB);
  endtask

  task automatic test_shortest_frames();
    send_frame(8'd1, 8'h00, 1'b1, 0, -1);
    send_frame(8'd1, 8'hFF, 1'b0, 0, -1);
  endtask

  task automatic test_zero_length();
    send_frame(8'd3, 8'h5A, 1'b1, 2, 8'hFF);
  endtask

  task automatic test_sync_in_frame();
    send_frame(8'd3, SyncByte, 1'b1, 0, SyncByte);
  endtask

  task automatic test_longest_frame();
    send_frame(8'd255, 8'($urandom), 1'b1, 0, -1);
  endtask

  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned pick;
    int unsigned len;
    int unsigned zeros;
    int unsigned extra;
    sent = 0;
    while (sent < RandomBytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        len = $urandom_range(0, 49);
        if (len < 45) len = $urandom_range(1, 12);
        else if (len < 49) len = $urandom_range(13, 64);
        else len = $urandom_range(65, 255);
        zeros = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
        send_frame(8'(len), 8'($urandom), $urandom_range(0, 5) != 0, zeros, -1);
        sent += len + 3 + zeros;
      end else if (pick < 90) begin
        extra = $urandom_range(1, 4);
        repeat (extra) send_byte(8'($urandom));
        sent += extra;
      end else begin
        // frame cut short; following bytes land inside it
        len = $urandom_range(2, 40);
        send_byte(SyncByte);
        send_byte(8'(len));
        extra = $urandom_range(0, len);
        repeat (extra) send_byte(8'($urandom));
        sent += 2 + extra;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_hunt_noise();
    test_shortest_frames();
    test_zero_length();
    test_sync_in_frame();
    test_longest_frame();
    test_random_traffic();
    s_axis_tvalid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/fmd_pkg.sv
hw/rtl/fmd_in_stage.sv
hw/rtl/fmd_parser.sv
hw/rtl/fmd_out_stage.sv
hw/rtl/framed_message_deframer.sv
bench/testbench.sv
